// ===== rtl/utf8_to_utf16_transcoder_assert.svh =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder assertion macros
// shared property forms for the transcoder checks
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH

// same-cycle implication, off during reset
`define UTT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define UTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/utt_pkg.sv =====
// ----------------------------------------------------------------------------
// utt_pkg
// types and constants shared by the transcoder front, queue and back
// ----------------------------------------------------------------------------
package utt_pkg;

  // replacement unit and surrogate bases
  localparam logic [15:0] ReplUnit  = 16'hFFFD;
  localparam logic [15:0] HiSurr    = 16'hD800;
  localparam logic [15:0] LoSurr    = 16'hDC00;
  localparam logic [15:0] SurrEnd   = 16'hDFFF;

  // code point limits
  localparam logic [20:0] SuppBase  = 21'h010000;
  localparam logic [20:0] MaxScalar = 21'h10FFFF;
  localparam logic [20:0] Min2Byte  = 21'h000080;
  localparam logic [20:0] Min3Byte  = 21'h000800;

  // one decoded byte worth of output: replacements first, then data units
  typedef struct packed {
    logic [2:0]  n_repl;
    logic [1:0]  n_data;
    logic [15:0] data0;
    logic [15:0] data1;
    logic        eos;
  } cmd_t;

  // command queue status
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== rtl/utt_front.sv =====
// ----------------------------------------------------------------------------
// utt_front
// classifies accepted bytes against the open sequence and issues unit commands
// ----------------------------------------------------------------------------
module utt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic [7:0]    in_byte_i,
  input  logic          eos_i,
  output utt_pkg::cmd_t cmd_o,
  output logic          cmd_push_o
);

  logic [1:0]  seq_total_q, seq_total_d;
  logic [1:0]  held_q, held_d;
  logic [20:0] part_q, part_d;

  logic        open_seq;
  logic        is_cont;
  logic [2:0]  pre_repl;
  logic [2:0]  held_inc;
  logic [2:0]  tot_inc;
  logic [20:0] pv;
  logic [20:0] w_full;
  logic        bad;
  logic [1:0]  lead_tot;
  logic [20:0] lead_part;
  logic        is_lead;

  assign open_seq = (seq_total_q != 2'd0);
  assign is_cont  = (in_byte_i[7:6] == 2'b10);
  assign pre_repl = open_seq ? {1'b0, held_q} : 3'd0;
  assign held_inc = {1'b0, held_q} + 3'd1;
  assign tot_inc  = {1'b0, seq_total_q} + 3'd1;
  assign pv       = {part_q[14:0], in_byte_i[5:0]};
  assign w_full   = pv - utt_pkg::SuppBase;

  // lead byte decode
  always_comb begin
    is_lead   = 1'b1;
    lead_tot  = 2'd0;
    lead_part = '0;
    if (in_byte_i[7:5] == 3'b110) begin
      lead_tot  = 2'd1;
      lead_part = {16'd0, in_byte_i[4:0]};
    end else if (in_byte_i[7:4] == 4'b1110) begin
      lead_tot  = 2'd2;
      lead_part = {17'd0, in_byte_i[3:0]};
    end else if (in_byte_i[7:3] == 5'b11110) begin
      lead_tot  = 2'd3;
      lead_part = {18'd0, in_byte_i[2:0]};
    end else begin
      is_lead = 1'b0;
    end
  end

  // value checks on a completed sequence
  always_comb begin
    case (seq_total_q)
      2'd1:    bad = (pv < utt_pkg::Min2Byte);
      2'd2:    bad = (pv < utt_pkg::Min3Byte) ||
                     ((pv >= {5'd0, utt_pkg::HiSurr}) && (pv <= {5'd0, utt_pkg::SurrEnd}));
      default: bad = (pv < utt_pkg::SuppBase) || (pv > utt_pkg::MaxScalar);
    endcase
  end

  // command and next sequence state
  always_comb begin
    cmd_o        = '0;
    cmd_o.eos    = eos_i;
    seq_total_d  = seq_total_q;
    held_d       = held_q;
    part_d       = part_q;
    if (open_seq && is_cont) begin
      if (held_inc == tot_inc) begin
        seq_total_d = 2'd0;
        held_d      = 2'd0;
        part_d      = '0;
        if (bad) begin
          cmd_o.n_repl = tot_inc;
        end else if (seq_total_q == 2'd3) begin
          cmd_o.n_data = 2'd2;
          cmd_o.data0  = utt_pkg::HiSurr + {6'd0, w_full[19:10]};
          cmd_o.data1  = utt_pkg::LoSurr + {6'd0, w_full[9:0]};
        end else begin
          cmd_o.n_data = 2'd1;
          cmd_o.data0  = pv[15:0];
        end
      end else if (eos_i) begin
        cmd_o.n_repl = held_inc;
        seq_total_d  = 2'd0;
        held_d       = 2'd0;
        part_d       = '0;
      end else begin
        held_d = held_inc[1:0];
        part_d = pv;
      end
    end else begin
      // fresh decode, after flushing any held bytes of a broken sequence
      seq_total_d = 2'd0;
      held_d      = 2'd0;
      part_d      = '0;
      if (!in_byte_i[7]) begin
        cmd_o.n_repl = pre_repl;
        cmd_o.n_data = 2'd1;
        cmd_o.data0  = {8'd0, in_byte_i};
      end else if (is_lead && !eos_i) begin
        cmd_o.n_repl = pre_repl;
        seq_total_d  = lead_tot;
        held_d       = 2'd1;
        part_d       = lead_part;
      end else begin
        cmd_o.n_repl = pre_repl + 3'd1;
      end
    end
  end

  assign cmd_push_o = fire_i && ((cmd_o.n_repl != 3'd0) || (cmd_o.n_data != 2'd0));

  // sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_total_q <= 2'd0;
      held_q      <= 2'd0;
      part_q      <= '0;
    end else if (fire_i) begin
      seq_total_q <= seq_total_d;
      held_q      <= held_d;
      part_q      <= part_d;
    end
  end

endmodule

// ===== rtl/utt_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// utt_cmd_fifo
// short command queue that decouples byte decode from unit output
// ----------------------------------------------------------------------------
module utt_cmd_fifo #(
  parameter int unsigned CmdDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  utt_pkg::cmd_t       wdata_i,
  input  logic                pop_i,
  output utt_pkg::cmd_t       rdata_o,
  output utt_pkg::fifo_stat_t stat_o
);

  localparam int unsigned PtrW = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
  localparam int unsigned CntW = $clog2(CmdDepth + 1);

  utt_pkg::cmd_t mem_q [CmdDepth];

  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign stat_o.full  = (count_q == CntW'(CmdDepth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rdata_o      = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(CmdDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(CmdDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/utt_back.sv =====
// ----------------------------------------------------------------------------
// utt_back
// walks each command one code unit per cycle into the free output register
// ----------------------------------------------------------------------------
module utt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  utt_pkg::cmd_t cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [15:0]   code_unit_o,
  output logic          last_unit_o
);

  logic        out_valid_q;
  logic [15:0] code_q;
  logic        last_q;
  logic [1:0]  idx_q;

  logic [2:0]  total;
  logic [2:0]  idx_ext;
  logic        last_of_cmd;
  logic        load;
  logic [15:0] unit;

  assign total       = cmd_i.n_repl + {1'b0, cmd_i.n_data};
  assign idx_ext     = {1'b0, idx_q};
  assign last_of_cmd = ((idx_ext + 3'd1) == total);
  assign load        = cmd_valid_i && (!out_valid_q || pop_i);
  assign cmd_pop_o   = load && last_of_cmd;

  // unit select: replacements lead, data units follow
  always_comb begin
    if (idx_ext < cmd_i.n_repl) begin
      unit = utt_pkg::ReplUnit;
    end else if (idx_ext == cmd_i.n_repl) begin
      unit = cmd_i.data0;
    end else begin
      unit = cmd_i.data1;
    end
  end

  // output beat register and position within the command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      idx_q       <= last_of_cmd ? 2'd0 : idx_q + 2'd1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      code_q <= unit;
      last_q <= cmd_i.eos && last_of_cmd;
    end
  end

  assign empty_o     = !out_valid_q;
  assign code_unit_o = code_q;
  assign last_unit_o = last_q;

endmodule

// ===== rtl/utf8_to_utf16_transcoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// utf-8 byte stream in, utf-16 code units out, 0xFFFD on malformed input
// ----------------------------------------------------------------------------
// channel   dir  handshake       payload
// byte in   in   push/full       in_byte_i[7:0], end_of_string_i
// unit out  out  pop/empty       code_unit_o[15:0], last_unit_o
//
// one byte is accepted per cycle while the command queue has room
// each byte yields 0 to 4 units; the back end emits a unit per cycle while popped,
// so bursts of replacement units or surrogate pairs fill the queue and stall input
// first unit of a byte goes through the command queue, then the output register
// reset clears the open sequence and empties the queue and the output register
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_transcoder_assert.svh"

module utf8_to_utf16_transcoder #(
  parameter int unsigned CmdDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_string_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] code_unit_o,
  output logic        last_unit_o
);

  utt_pkg::cmd_t       front_cmd;
  utt_pkg::cmd_t       head_cmd;
  utt_pkg::fifo_stat_t q_stat;
  logic                front_push;
  logic                back_pop;
  logic                in_fire;

  assign full    = q_stat.full;
  assign in_fire = push && !q_stat.full;

  // byte classification and sequence state
  utt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (in_fire),
    .in_byte_i  (in_byte_i),
    .eos_i      (end_of_string_i),
    .cmd_o      (front_cmd),
    .cmd_push_o (front_push)
  );

  // command queue
  utt_cmd_fifo #(
    .CmdDepth (CmdDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .wdata_i (front_cmd),
    .pop_i   (back_pop),
    .rdata_o (head_cmd),
    .stat_o  (q_stat)
  );

  // unit serializer and output register
  utt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .cmd_valid_i (!q_stat.empty),
    .cmd_pop_o   (back_pop),
    .pop_i       (pop && !empty),
    .empty_o     (empty),
    .code_unit_o (code_unit_o),
    .last_unit_o (last_unit_o)
  );

  // a byte never asks for more than four units
  `UTT_ASSERT_IMPLY(a_cmd_bound, clk_i, rst_ni, front_push,
    (front_cmd.n_repl + {1'b0, front_cmd.n_data}) <= 3'd4, "command exceeds four units")

  // the last byte of a string always leaves a command carrying the end mark
  `UTT_ASSERT_IMPLY(a_eos_cmd, clk_i, rst_ni, in_fire && end_of_string_i,
    front_push && front_cmd.eos, "end of string produced no command")

  // a waiting command reaches an idle output register in the next cycle
  `UTT_ASSERT_NEXT(a_back_fill, clk_i, rst_ni, !q_stat.empty && empty,
    !empty, "queued command not moved to output")

endmodule

// ===== sim/utf8_to_utf16_transcoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_tb
// self-checking bench: utf-8 strings in, utf-16 code units checked in order
// ----------------------------------------------------------------------------
// a directed set covers ascii limits, each sequence length, stray and out of
// range bytes, broken and cut sequences, overlong forms, encoded surrogates
// and values above the last scalar; random strings follow, mostly well
// formed with some noise. a scoreboard class decodes every accepted beat and
// compares each popped unit with the oldest expected one. both sides idle at
// random, the receiver holds off once to fill the block, and the sender
// pauses once until all units have drained.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_tb;

  localparam int unsigned CycleLimit      = 200000;
  localparam int unsigned MaxUnitsPerByte = 4;
  localparam int unsigned RandomBytes     = 320;
  localparam int unsigned DrainCycles     = 20;
  localparam int unsigned IdlePercent     = 19;

  typedef struct packed {
    logic [15:0] code;
    logic        last;
  } unit_t;

  // decodes accepted bytes into expected units and checks popped units
  class utf16_unit_scoreboard;
    unit_t       units_due[$];
    unit_t       step_units[$];
    logic [1:0]  open_need  = 2'd0;
    logic [1:0]  open_held  = 2'd0;
    logic [20:0] gathered   = 21'd0;
    int          bytes_seen = 0;
    int          strings_seen = 0;
    int          units_checked = 0;
    int          repl_seen  = 0;
    int          errors     = 0;

    function int pending();
      return units_due.size();
    endfunction

    function void emit_unit(logic [15:0] code);
      unit_t u;
      u.code = code;
      u.last = 1'b0;
      if (step_units.size() < MaxUnitsPerByte) step_units.insert(step_units.size(), u);
    endfunction

    function void replace(int count);
      for (int i = 0; i < count; i++) emit_unit(utt_pkg::ReplUnit);
    endfunction

    function void close_open();
      open_need = 2'd0;
      open_held = 2'd0;
      gathered  = 21'd0;
    endfunction

    // byte with no sequence open: ascii, lead or stray
    function void decode_fresh(logic [7:0] b, logic eos);
      if (b < 8'h80) begin
        emit_unit({8'h00, b});
      end else if (b >= 8'hC0 && b <= 8'hDF) begin
        open_need = 2'd1;
        open_held = 2'd1;
        gathered  = {16'd0, b[4:0]};
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        open_need = 2'd2;
        open_held = 2'd1;
        gathered  = {17'd0, b[3:0]};
      end else if (b >= 8'hF0 && b <= 8'hF7) begin
        open_need = 2'd3;
        open_held = 2'd1;
        gathered  = {18'd0, b[2:0]};
      end else begin
        emit_unit(utt_pkg::ReplUnit);
      end
      // lead byte on the end of the string
      if (eos && open_need != 2'd0) begin
        replace(int'(open_held));
        close_open();
      end
    endfunction

    // complete sequence: range checks, then one unit or a surrogate pair
    function void finish_code_point();
      logic        bad;
      logic [20:0] w;
      case (open_need)
        2'd1:    bad = gathered < utt_pkg::Min2Byte;
        2'd2:    bad = gathered < utt_pkg::Min3Byte ||
                       (gathered >= {5'd0, utt_pkg::HiSurr} &&
                        gathered <= {5'd0, utt_pkg::SurrEnd});
        default: bad = gathered < utt_pkg::SuppBase || gathered > utt_pkg::MaxScalar;
      endcase
      if (bad) begin
        replace(int'(open_need) + 1);
      end else if (open_need == 2'd3) begin
        w = gathered - utt_pkg::SuppBase;
        emit_unit(utt_pkg::HiSurr + {6'd0, w[19:10]});
        emit_unit(utt_pkg::LoSurr + {6'd0, w[9:0]});
      end else begin
        emit_unit(gathered[15:0]);
      end
      close_open();
    endfunction

    function void decode_byte(logic [7:0] b, logic eos);
      int held;
      step_units.delete();
      if (open_need != 2'd0) begin
        if (b[7:6] == 2'b10) begin
          held     = int'(open_held) + 1;
          gathered = {gathered[14:0], b[5:0]};
          if (held >= int'(open_need) + 1) begin
            finish_code_point();
          end else if (eos) begin
            replace(held);
            close_open();
          end else begin
            open_held = held[1:0];
          end
        end else begin
          // broken sequence: flush held bytes, then decode this one afresh
          replace(int'(open_held));
          close_open();
          decode_fresh(b, eos);
        end
      end else begin
        decode_fresh(b, eos);
      end
      if (eos && step_units.size() > 0) step_units[step_units.size() - 1].last = 1'b1;
      foreach (step_units[i]) units_due.insert(units_due.size(), step_units[i]);
    endfunction

    function void note_byte(logic [7:0] b, logic eos);
      bytes_seen++;
      if (eos) strings_seen++;
      decode_byte(b, eos);
    endfunction

    function void check_unit(logic [15:0] code, logic last);
      unit_t due;
      units_checked++;
      if (code == utt_pkg::ReplUnit) repl_seen++;
      if (units_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected unit, expected none, actual code %h last %b",
                 $time, code, last);
        return;
      end
      due = units_due.pop_front();
      if (code !== due.code) begin
        errors++;
        $display("%0t: code_unit mismatch, expected %h, actual %h", $time, due.code, code);
      end
      if (last !== due.last) begin
        errors++;
        $display("%0t: last_unit mismatch, expected %b, actual %b", $time, due.last, last);
      end
    endfunction
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        push            = 1'b0;
  logic        full;
  logic [7:0]  in_byte_i       = 8'h00;
  logic        end_of_string_i = 1'b0;
  logic        empty;
  logic        pop             = 1'b0;
  logic [15:0] code_unit_o;
  logic        last_unit_o;

  utf16_unit_scoreboard board;
  logic [7:0]  str_q[$];
  int unsigned cycle_count  = 0;
  int          stall_cycles = 0;
  bit          steady       = 1'b0;
  int          bytes_sent   = 0;

  utf8_to_utf16_transcoder uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .in_byte_i      (in_byte_i),
    .end_of_string_i(end_of_string_i),
    .empty          (empty),
    .pop            (pop),
    .code_unit_o    (code_unit_o),
    .last_unit_o    (last_unit_o)
  );

  // clock
  always #6 clk_i = ~clk_i;

  // beat monitor: note accepted bytes before checking popped units
  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni) begin
      if (push && !full) board.note_byte(in_byte_i, end_of_string_i);
      if (pop && !empty) board.check_unit(code_unit_o, last_unit_o);
    end
  end

  // receiver: random idling, long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (stall_cycles > 0) begin
      stall_cycles--;
      pop <= 1'b0;
    end else begin
      pop <= steady || ($urandom_range(0, 99) >= IdlePercent);
    end
  end

  // run limit
  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("** utf8_to_utf16_transcoder: FAILED **");
    $finish;
  end

  // one beat on the byte side, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic eos);
    while (!steady && $urandom_range(0, 99) < IdlePercent) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push            <= 1'b1;
    in_byte_i       <= b;
    end_of_string_i <= eos;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
  endtask

  // send str_q with the end flag on its last byte
  task automatic send_string();
    foreach (str_q[i]) send_byte(str_q[i], i == str_q.size() - 1);
  endtask

  // stop offering bytes until every expected unit has been popped
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  // add one byte at the tail of str_q
  task automatic append_byte(input logic [7:0] b);
    str_q.insert(str_q.size(), b);
  endtask

  // append cp encoded in len bytes; len may exceed the shortest form
  task automatic add_code_point(input logic [20:0] cp, input int len);
    case (len)
      1: append_byte({1'b0, cp[6:0]});
      2: begin
        append_byte({3'b110, cp[10:6]});
        append_byte({2'b10, cp[5:0]});
      end
      3: begin
        append_byte({4'b1110, cp[15:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
      default: begin
        append_byte({5'b11110, cp[20:18]});
        append_byte({2'b10, cp[17:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // random string: mostly valid characters, some malformed input
  task automatic build_string(input int n_chars);
    int          kind;
    int          len;
    logic [20:0] cp;
    str_q.delete();
    repeat (n_chars) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        add_code_point(21'($urandom_range(0, 8'h7F)), 1);
      end else if (kind < 45) begin
        add_code_point(21'($urandom_range(12'h080, 12'h7FF)), 2);
      end else if (kind < 60) begin
        cp = 21'($urandom_range(16'h0800, 16'hFFFF));
        if (cp >= {5'd0, utt_pkg::HiSurr} && cp <= {5'd0, utt_pkg::SurrEnd}) begin
          cp = cp ^ 21'h002000;
        end
        add_code_point(cp, 3);
      end else if (kind < 75) begin
        add_code_point(21'($urandom_range(21'h010000, 21'h10FFFF)), 4);
      end else if (kind < 79) begin
        // stray continuation byte
        append_byte(8'($urandom_range(8'h80, 8'hBF)));
      end else if (kind < 84) begin
        append_byte(8'($urandom_range(0, 255)));
      end else if (kind < 92) begin
        // valid sequence with its tail cut off
        len = $urandom_range(2, 4);
        case (len)
          2:       add_code_point(21'($urandom_range(12'h080, 12'h7FF)), 2);
          3:       add_code_point(21'($urandom_range(16'h0800, 16'hFFFF)), 3);
          default: add_code_point(21'($urandom_range(21'h010000, 21'h10FFFF)), 4);
        endcase
        repeat ($urandom_range(1, len - 1)) void'(str_q.pop_back());
      end else if (kind < 95) begin
        // overlong form
        len = $urandom_range(2, 4);
        case (len)
          2:       add_code_point(21'($urandom_range(0, 8'h7F)), 2);
          3:       add_code_point(21'($urandom_range(0, 12'h7FF)), 3);
          default: add_code_point(21'($urandom_range(0, 16'hFFFF)), 4);
        endcase
      end else if (kind < 98) begin
        add_code_point(21'($urandom_range(utt_pkg::HiSurr, utt_pkg::SurrEnd)), 3);
      end else begin
        add_code_point(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
      end
    end
  endtask

  initial begin
    board = new;

    // reset
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ascii limits
    str_q = '{8'h00, 8'h7F};
    send_string();
    // smallest two-byte, largest three-byte, largest scalar as a pair
    str_q = '{8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_string();
    // stray bytes, then a four-byte sequence broken after three bytes
    str_q = '{8'h80, 8'hFF, 8'hF0, 8'h9F, 8'h98, 8'h41};
    send_string();
    // encoded surrogate, overlong, above last scalar, cut by end of string
    str_q = '{8'hED, 8'hA0, 8'h80, 8'hC0, 8'hAF, 8'hF5, 8'h80, 8'h80, 8'h80,
              8'hF0, 8'h9F};
    send_string();
    // lead byte alone as the whole string
    str_q = '{8'hE2};
    send_string();

    // sender pause until everything has drained
    wait_drained();

    // stretch with no idling on either side
    steady = 1'b1;
    while (bytes_sent < 100) begin
      build_string($urandom_range(1, 10));
      send_string();
    end
    steady = 1'b0;

    // receiver holds off while bytes keep coming, so the block fills
    stall_cycles = 80;
    build_string(24);
    send_string();

    // random strings
    while (bytes_sent < RandomBytes) begin
      build_string($urandom_range(1, 12));
      send_string();
    end

    // drain and let the pipeline settle
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (board.pending() != 0) begin
      board.errors++;
      $display("%0t: %0d expected units never arrived", $time, board.pending());
    end

    $display("covered %0d bytes in %0d strings, %0d units popped, %0d of them replacements",
             board.bytes_seen, board.strings_seen, board.units_checked, board.repl_seen);
    $display("including long receiver hold-off and a full drain pause on the sender side");
    if (board.errors == 0) begin
      $display("** utf8_to_utf16_transcoder: PASSED **");
    end else begin
      $display("** utf8_to_utf16_transcoder: FAILED **");
    end
    $finish;
  end

endmodule
